// ===== hw/rtl/mrbv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the multi-read bit vote fusion block.
// No dependencies; used by mrbv_vote, mrbv_div and the top level.

package mrbv_pkg;

  localparam int unsigned MAX_REVS        = 8;
  localparam int unsigned MAX_TRACK_BYTES = 32768;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ScoreW  = 7;
  localparam int unsigned CountW  = 19;
  localparam int unsigned RevCntW = 4;
  localparam int unsigned ScoresW = 56;
  localparam int unsigned LaneW   = 3;
  localparam int unsigned WSumW   = 10;  // up to 8 x 100
  localparam int unsigned ConfW   = 7;

  // shared divider geometry: quotient is known to stay below 2**DivQuoW
  localparam int unsigned DivNumW = 31;
  localparam int unsigned DivDenW = 24;
  localparam int unsigned DivQuoW = 7;
  localparam int unsigned DivStpW = 3;

  localparam logic [ScoreW-1:0] ScoreMax  = 7'd100;
  localparam logic [CountW-1:0] CountSat  = '1;

  // configuration register indexes
  localparam logic [1:0] CfgMode     = 2'd0;
  localparam logic [1:0] CfgRevCount = 2'd1;
  localparam logic [1:0] CfgScores   = 2'd2;

  typedef enum logic [1:0] {
    ModeMajority = 2'd0,
    ModeBestRev  = 2'd1,
    ModeWeighted = 2'd2,
    ModeHighConf = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StBits,
    StMeanGo,
    StMeanWait,
    StPrep,
    StMul,
    StConfGo,
    StConfWait,
    StDone
  } state_e;

  typedef struct packed {
    logic bit_val;
    logic count_en;
    logic agreed;
    logic low_agree;
  } vote_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // 7-bit score of revolution idx, clamped to 100
  function automatic logic [ScoreW-1:0] score_of(input logic [ScoresW-1:0] scores,
                                                 input logic [LaneW-1:0]   idx);
    logic [ScoreW-1:0] raw;
    raw = scores[idx*ScoreW +: ScoreW];
    return (raw > ScoreMax) ? ScoreMax : raw;
  endfunction

  // revolution count clamped into 1..MAX_REVS
  function automatic logic [RevCntW-1:0] clamp_revs(input logic [RevCntW-1:0] cnt);
    logic [RevCntW-1:0] res;
    res = cnt;
    if (cnt == '0) res = RevCntW'(1);
    else if (cnt > RevCntW'(MAX_REVS)) res = RevCntW'(MAX_REVS);
    return res;
  endfunction

endpackage

// ===== hw/rtl/multi_read_bit_vote_fusion.sv =====
`timescale 1ns / 1ps
// Top level of the multi-read bit vote fusion block: sequencer, lane scan, counters.
// Depends on mrbv_pkg, mrbv_vote and mrbv_div.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in      | input     | in_valid_i/in_ready_o | rev_byte_0..7, present_mask, final_byte
//  out     | output    | out_valid_o/out_ready_i | fused data, counts, confidence, done
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Per byte: accept, scan the lanes of the clamped revolution count, run the bit steps in
// majority and weighted modes, then load the output register.
// A final byte adds a divider pass for the mean (start, quotient bits, done), and, once
// any bit was voted without full agreement, the ratio steps (prep, mul) plus a second pass.
// in_ready_o is high only while idle; the load waits while the previous result is unaccepted.
// Reset clears the sequencer and the counters and sets the config registers to defaults; cfg is always ready.

module multi_read_bit_vote_fusion (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_0_i,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_1_i,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_2_i,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_3_i,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_4_i,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_5_i,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_6_i,
  input  logic [mrbv_pkg::ByteW-1:0]        rev_byte_7_i,
  input  logic [mrbv_pkg::ByteW-1:0]        present_mask_i,
  input  logic                              final_byte_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mrbv_pkg::ByteW-1:0]        fused_data_o,
  output logic [mrbv_pkg::CountW-1:0]       agreed_bits_o,
  output logic [mrbv_pkg::CountW-1:0]       voted_bits_o,
  output logic [mrbv_pkg::CountW-1:0]       weak_bits_o,
  output logic [mrbv_pkg::ConfW-1:0]        overall_confidence_o,
  output logic                              track_done_o,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [mrbv_pkg::ScoresW-1:0]      cfg_data_i
);

  localparam int unsigned NB = mrbv_pkg::ByteW;
  localparam int unsigned NR = mrbv_pkg::MAX_REVS;

  // config registers
  mrbv_pkg::mode_e                   mode_q;
  logic [mrbv_pkg::RevCntW-1:0]      revcnt_q;
  logic [mrbv_pkg::ScoresW-1:0]      scores_q;

  // sequencer
  mrbv_pkg::state_e                  state_q, state_d;
  logic [mrbv_pkg::LaneW-1:0]        lane_q;
  logic [2:0]                        bit_q;

  // latched item
  logic [NB-1:0]                     bytes_q [NR];
  logic [NB-1:0]                     present_q;
  logic                              fin_q;

  // lane-scan accumulators
  logic [3:0]                        valid_q;
  logic [3:0]                        ones_q  [NB];
  logic [mrbv_pkg::WSumW-1:0]        wones_q [NB];
  logic [mrbv_pkg::WSumW-1:0]        wtotal_q;
  logic [mrbv_pkg::WSumW-1:0]        sum_q;
  logic [mrbv_pkg::ScoreW-1:0]       best1_sc_q, best3_sc_q;
  logic [NB-1:0]                     best1_byte_q, best3_byte_q;
  logic                              best1_pres_q;
  logic [NB-1:0]                     fused_q;

  // running counts
  logic [mrbv_pkg::CountW-1:0]       agreed_q, voted_q, weak_q;

  // confidence path
  logic [mrbv_pkg::ConfW-1:0]        mean_q, conf_q;
  logic [mrbv_pkg::DivDenW-1:0]      factor_q, den_q;
  logic [mrbv_pkg::DivNumW-1:0]      num_q;

  // output register
  logic                              out_valid_q;
  logic [NB-1:0]                     out_fused_q;
  logic [mrbv_pkg::CountW-1:0]       out_agreed_q, out_voted_q, out_weak_q;
  logic [mrbv_pkg::ConfW-1:0]        out_conf_q;
  logic                              out_done_q;

  // control
  logic                              in_xfer, out_load, div_start;
  logic [mrbv_pkg::RevCntW-1:0]      n_revs;
  logic [mrbv_pkg::LaneW-1:0]        last_lane;
  logic [mrbv_pkg::ScoreW-1:0]       lane_sc;
  logic [NB-1:0]                     lane_byte;
  logic                              lane_pres;
  logic                              bitwise_mode;
  logic [mrbv_pkg::DivNumW-1:0]      div_num;
  logic [mrbv_pkg::DivDenW-1:0]      div_den;
  logic [mrbv_pkg::DivQuoW-1:0]      div_quo;
  mrbv_pkg::div_stat_t               div_stat;
  mrbv_pkg::vote_t                   vote;
  logic [NB-1:0]                     fused_sel;

  assign n_revs       = mrbv_pkg::clamp_revs(revcnt_q);
  assign last_lane    = mrbv_pkg::LaneW'(n_revs - 1'b1);
  assign lane_sc      = mrbv_pkg::score_of(scores_q, lane_q);
  assign lane_byte    = bytes_q[lane_q];
  assign lane_pres    = present_q[lane_q];
  assign bitwise_mode = (mode_q == mrbv_pkg::ModeMajority) ||
                        (mode_q == mrbv_pkg::ModeWeighted);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign cfg_ready_o  = 1'b1;

  // ---------------------------------------------------------------- config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mrbv_pkg::ModeMajority;
      revcnt_q <= mrbv_pkg::RevCntW'(2);
      scores_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mrbv_pkg::CfgMode:     mode_q   <= mrbv_pkg::mode_e'(cfg_data_i[1:0]);
        mrbv_pkg::CfgRevCount: revcnt_q <= cfg_data_i[mrbv_pkg::RevCntW-1:0];
        mrbv_pkg::CfgScores:   scores_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mrbv_pkg::StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    div_num    = mrbv_pkg::DivNumW'(sum_q);
    div_den    = mrbv_pkg::DivDenW'(n_revs);
    unique case (state_q)
      mrbv_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = mrbv_pkg::StScan;
      end
      mrbv_pkg::StScan: begin
        if (lane_q == last_lane) begin
          if (bitwise_mode)  state_d = mrbv_pkg::StBits;
          else if (fin_q)    state_d = mrbv_pkg::StMeanGo;
          else               state_d = mrbv_pkg::StDone;
        end
      end
      mrbv_pkg::StBits: begin
        if (bit_q == 3'd7) state_d = fin_q ? mrbv_pkg::StMeanGo : mrbv_pkg::StDone;
      end
      mrbv_pkg::StMeanGo: begin
        div_start = 1'b1;
        state_d   = mrbv_pkg::StMeanWait;
      end
      mrbv_pkg::StMeanWait: begin
        if (div_stat.done) state_d = (voted_q != '0) ? mrbv_pkg::StPrep : mrbv_pkg::StDone;
      end
      mrbv_pkg::StPrep: state_d = mrbv_pkg::StMul;
      mrbv_pkg::StMul:  state_d = mrbv_pkg::StConfGo;
      mrbv_pkg::StConfGo: begin
        div_start = 1'b1;
        div_num   = num_q;
        div_den   = den_q;
        state_d   = mrbv_pkg::StConfWait;
      end
      mrbv_pkg::StConfWait: begin
        if (div_stat.done) state_d = mrbv_pkg::StDone;
      end
      mrbv_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = mrbv_pkg::StIdle;
        end
      end
      default: state_d = mrbv_pkg::StIdle;
    endcase
  end

  // ---------------------------------------------------------------- shared units
  mrbv_vote u_vote (
    .mode_i   (mode_q),
    .valid_i  (valid_q),
    .ones_i   (ones_q[bit_q]),
    .wtotal_i (wtotal_q),
    .wones_i  (wones_q[bit_q]),
    .vote_o   (vote)
  );

  mrbv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      bytes_q[0]   <= rev_byte_0_i;
      bytes_q[1]   <= rev_byte_1_i;
      bytes_q[2]   <= rev_byte_2_i;
      bytes_q[3]   <= rev_byte_3_i;
      bytes_q[4]   <= rev_byte_4_i;
      bytes_q[5]   <= rev_byte_5_i;
      bytes_q[6]   <= rev_byte_6_i;
      bytes_q[7]   <= rev_byte_7_i;
      present_q    <= present_mask_i;
      fin_q        <= final_byte_i;
      lane_q       <= '0;
      bit_q        <= '0;
      valid_q      <= '0;
      wtotal_q     <= '0;
      sum_q        <= '0;
      for (int b = 0; b < NB; b++) begin
        ones_q[b]  <= '0;
        wones_q[b] <= '0;
      end
      // best revolution starts at revolution 0 with score 0
      best1_sc_q   <= '0;
      best1_byte_q <= rev_byte_0_i;
      best1_pres_q <= present_mask_i[0];
      best3_sc_q   <= '0;
      best3_byte_q <= '0;
      conf_q       <= '0;
    end

    if (state_q == mrbv_pkg::StScan) begin
      lane_q <= lane_q + 1'b1;
      sum_q  <= sum_q + mrbv_pkg::WSumW'(lane_sc);
      if (lane_sc > best1_sc_q) begin
        best1_sc_q   <= lane_sc;
        best1_byte_q <= lane_byte;
        best1_pres_q <= lane_pres;
      end
      if (lane_pres) begin
        valid_q  <= valid_q + 1'b1;
        wtotal_q <= wtotal_q + mrbv_pkg::WSumW'(lane_sc);
        for (int b = 0; b < NB; b++) begin
          ones_q[b]  <= ones_q[b] + 4'(lane_byte[b]);
          wones_q[b] <= wones_q[b] + (lane_byte[b] ? mrbv_pkg::WSumW'(lane_sc) : '0);
        end
        if (lane_sc > best3_sc_q) begin
          best3_sc_q   <= lane_sc;
          best3_byte_q <= lane_byte;
        end
      end
    end

    // fused bits shift in LSB first
    if (state_q == mrbv_pkg::StBits) begin
      bit_q   <= bit_q + 1'b1;
      fused_q <= {vote.bit_val, fused_q[NB-1:1]};
    end

    if (state_q == mrbv_pkg::StMeanWait && div_stat.done) begin
      mean_q <= div_quo;
      if (voted_q == '0) conf_q <= div_quo;
    end
    if (state_q == mrbv_pkg::StPrep) begin
      factor_q <= mrbv_pkg::DivDenW'(agreed_q) * mrbv_pkg::DivDenW'(10) +
                  mrbv_pkg::DivDenW'(voted_q)  * mrbv_pkg::DivDenW'(7);
      den_q    <= (mrbv_pkg::DivDenW'(agreed_q) + mrbv_pkg::DivDenW'(voted_q)) *
                  mrbv_pkg::DivDenW'(10);
    end
    if (state_q == mrbv_pkg::StMul) begin
      num_q <= mrbv_pkg::DivNumW'(mean_q) * mrbv_pkg::DivNumW'(factor_q);
    end
    if (state_q == mrbv_pkg::StConfWait && div_stat.done) conf_q <= div_quo;
  end

  // running counts, saturating; cleared once the final byte's result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agreed_q <= '0;
      voted_q  <= '0;
      weak_q   <= '0;
    end else if (out_load && fin_q) begin
      agreed_q <= '0;
      voted_q  <= '0;
      weak_q   <= '0;
    end else if (state_q == mrbv_pkg::StBits && vote.count_en) begin
      if (vote.agreed) begin
        if (agreed_q != mrbv_pkg::CountSat) agreed_q <= agreed_q + 1'b1;
      end else begin
        if (voted_q != mrbv_pkg::CountSat) voted_q <= voted_q + 1'b1;
      end
      if (vote.low_agree && weak_q != mrbv_pkg::CountSat) weak_q <= weak_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    case (mode_q)
      mrbv_pkg::ModeBestRev:  fused_sel = best1_pres_q ? best1_byte_q : '0;
      mrbv_pkg::ModeHighConf: fused_sel = best3_byte_q;
      default:                fused_sel = fused_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fused_q  <= fused_sel;
      out_agreed_q <= agreed_q;
      out_voted_q  <= voted_q;
      out_weak_q   <= weak_q;
      out_conf_q   <= conf_q;
      out_done_q   <= fin_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign fused_data_o         = out_fused_q;
  assign agreed_bits_o        = out_agreed_q;
  assign voted_bits_o         = out_voted_q;
  assign weak_bits_o          = out_weak_q;
  assign overall_confidence_o = out_conf_q;
  assign track_done_o         = out_done_q;

  // ---------------------------------------------------------------- assertions
  a_conf_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !track_done_o) |-> (overall_confidence_o == '0))
    else $error("confidence nonzero on a non-final result");

  a_conf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (overall_confidence_o <= mrbv_pkg::ConfW'(100)))
    else $error("confidence above 100");

  a_counts_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && fin_q) |=> (agreed_q == '0 && voted_q == '0 && weak_q == '0))
    else $error("counts not cleared after end of track");

  a_counts_majority_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrbv_pkg::StBits && mode_q != mrbv_pkg::ModeMajority)
      |=> ($stable(agreed_q) && $stable(voted_q) && $stable(weak_q)))
    else $error("counts moved outside majority mode");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == mrbv_pkg::StMeanWait ||
                       state_q == mrbv_pkg::StConfWait))
    else $error("divider finished while not awaited");

endmodule

// ===== hw/rtl/mrbv_vote.sv =====
`timescale 1ns / 1ps
// Per-bit decision unit: majority or score-weighted vote for one bit position.
// Depends on mrbv_pkg.

module mrbv_vote (
  input  mrbv_pkg::mode_e                 mode_i,
  input  logic [3:0]                      valid_i,
  input  logic [3:0]                      ones_i,
  input  logic [mrbv_pkg::WSumW-1:0]      wtotal_i,
  input  logic [mrbv_pkg::WSumW-1:0]      wones_i,
  output mrbv_pkg::vote_t                 vote_o
);

  logic       maj_bit;
  logic [3:0] agree;
  logic       w_bit;

  always_comb begin
    maj_bit = ones_i > (valid_i >> 1);
    agree   = maj_bit ? ones_i : (valid_i - ones_i);
    w_bit   = (wtotal_i != '0) && ({wones_i, 1'b0} > {1'b0, wtotal_i});

    case (mode_i)
      mrbv_pkg::ModeMajority: vote_o.bit_val = maj_bit;
      mrbv_pkg::ModeWeighted: vote_o.bit_val = w_bit;
      default:                vote_o.bit_val = 1'b0;
    endcase

    vote_o.count_en  = (mode_i == mrbv_pkg::ModeMajority) && (valid_i != '0);
    vote_o.agreed    = (agree == valid_i);
    // floor(100*agree/valid) < 70  <=>  10*agree < 7*valid
    vote_o.low_agree = (7'(agree) * 7'd10) < (7'(valid_i) * 7'd7);
  end

endmodule

// ===== hw/rtl/mrbv_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, quotient below 2**DivQuoW.
// Depends on mrbv_pkg.

module mrbv_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mrbv_pkg::DivNumW-1:0]      dividend_i,
  input  logic [mrbv_pkg::DivDenW-1:0]      divisor_i,
  output logic [mrbv_pkg::DivQuoW-1:0]      quotient_o,
  output mrbv_pkg::div_stat_t               stat_o
);

  logic [mrbv_pkg::DivNumW-1:0] rem_q, rem_d;
  logic [mrbv_pkg::DivNumW-1:0] dsh_q, dsh_d;
  logic [mrbv_pkg::DivQuoW-1:0] quo_q, quo_d;
  logic [mrbv_pkg::DivStpW-1:0] step_q, step_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic                         ge;

  always_comb begin
    ge     = rem_q >= dsh_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = mrbv_pkg::DivNumW'(divisor_i) << (mrbv_pkg::DivQuoW - 1);
      quo_d  = '0;
      step_d = mrbv_pkg::DivStpW'(mrbv_pkg::DivQuoW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_q - dsh_q) : rem_q;
      quo_d = {quo_q[mrbv_pkg::DivQuoW-2:0], ge};
      dsh_d = dsh_q >> 1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    step_q <= step_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
